FILE: hw/rtl/mono_framebuffer_draw_engine_macros.svh
// assertion macros used by the checker file of the draw engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// property checked at every rising clk edge, off while arst_n is low
`define ASSERT_AT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a rising clk edge
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_AT_CLK(lbl, !(cond), msg)

`endif

FILE: hw/rtl/mfb_pkg.sv
// constants and types of the monochrome framebuffer draw engine
package mfb_pkg;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 8;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int X_W         = $clog2(COLUMNS);
	localparam int WU_W        = $clog2(COLUMNS + 1);
	localparam int HU_W        = $clog2(PAGES * 8 + 1);
	localparam int PG_W        = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int LIM_W       = $clog2(STORE_BYTES + 1);
	// pixel coordinate: 16-bit value plus or minus a 16-bit offset
	localparam int CW          = 18;
	// circle decision variable
	localparam int EW          = 20;
	localparam int RW          = 17;

	localparam logic [2:0] ROW_BIT_MASK = 3'b111;
	localparam logic [7:0] BYTE_ONES    = 8'hff;
	localparam logic [7:0] BYTE_ZEROS   = 8'h00;

	typedef enum logic [2:0] {
		ACT_PIXEL  = 3'd0,
		ACT_HLINE  = 3'd1,
		ACT_VLINE  = 3'd2,
		ACT_FILL   = 3'd3,
		ACT_CIRCLE = 3'd4,
		ACT_WRITE  = 3'd5,
		ACT_READ   = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_WRITE,
		ST_FILL,
		ST_READ,
		ST_HOLD
	} state_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

FILE: hw/rtl/mfb_ram.sv
// frame store: one write port, one read port with registered read data
module mfb_ram (
	input  logic              clk,
	input  mfb_pkg::ram_req_t req,
	output logic [7:0]        rdata
);

	logic [7:0] mem [mfb_pkg::STORE_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

FILE: hw/rtl/mono_framebuffer_draw_engine.sv
// top level of the monochrome framebuffer draw engine
//
// Commands come in on the s_ channel, one item each; every command gives
// exactly one result item on the m_ channel (read byte and in-range flag).
// frame_width and frame_height are set through cfg_we/cfg_index/cfg_data;
// the user must write them only while no command is in flight; the block itself does not enforce it.
// Per command, from acceptance to the ready result: write byte, unused code,
//   and a pixel or read byte outside the frame, or a line starting outside it, finish on acceptance;
//   pixel and read byte inside the frame read the store, then finish;
//   hline and vline read and write back each drawn pixel; fill writes all
//   STORE_BYTES bytes; circle runs 8 plot slots per step, each clipped or
//   drawn. Because the store has a single port pair, a pixel
//   is a read in one cycle and the write back in the next.
// The result sits in an output register; a new command is taken as soon as
// the engine is idle, even while that result still waits. If the receiver
// stalls and a second result is ready, the engine holds it and stops
// taking commands until the output register frees up.
// After arst_n the store is cleared by a pass over all STORE_BYTES bytes, one
// byte a cycle; s_tready stays low during it, config writes still land.
module mono_framebuffer_draw_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x[15:0], pos_y[31:16], extent[47:32], color[48], byte_index[58:49],
	// byte_value[66:59], zero pad[71:67]
	input  logic [71:0] s_tdata,
	// action[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_value[7:0]
	output logic [7:0]  m_tdata,
	// in_range[0]
	output logic        m_tuser
);

	localparam int CW     = mfb_pkg::CW;
	localparam int EW     = mfb_pkg::EW;
	localparam int RW     = mfb_pkg::RW;
	localparam int ADDR_W = mfb_pkg::ADDR_W;

	mfb_pkg::state_t   state_q, state_d;
	mfb_pkg::ram_req_t ram_req;
	logic [7:0]        ram_rdata;

	logic [7:0] frame_width_q;
	logic [6:0] frame_height_q;

	logic [mfb_pkg::WU_W-1:0]  wu;
	logic [mfb_pkg::HU_W-1:0]  hu;
	logic [mfb_pkg::LIM_W-1:0] limit;

	// command fields
	mfb_pkg::action_t in_action;
	logic signed [CW-1:0] in_x, in_y;
	logic [15:0] in_ext;
	logic        in_color;
	logic [9:0]  in_bidx;
	logic [7:0]  in_bval;
	logic        bidx_ok;
	logic        accept;

	// walk registers
	mfb_pkg::action_t cmd_q;
	logic                 color_q;
	logic signed [CW-1:0] cx_q, cy_q, cur_q, end_q;
	logic signed [RW-1:0] x_q, y_q;
	logic signed [EW-1:0] err_q;
	logic [2:0]           oct_q;
	logic                 ok_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [7:0]           bit_q;
	logic [ADDR_W-1:0]    cnt_q;
	logic [7:0]           fill_q;

	// result registers
	logic       out_valid_q, out_ok_q, res_ok_q;
	logic [7:0] out_rd_q, res_rd_q;

	// combinational
	logic signed [CW-1:0] px_c, py_c, ox, oy, hend_sum, vend_sum;
	logic signed [CW-1:0] oa, ob;
	logic                 inside_c, done_c;
	logic [mfb_pkg::PG_W-1:0] page_c;
	logic [ADDR_W-1:0]    pix_addr;
	logic [7:0]           pix_bit;
	logic                 fin, fin_ok, latch_pix, adv, cnt_inc, out_free;
	logic [7:0]           fin_rd;
	logic signed [RW-1:0] y_n, x_n;

	mfb_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign wu = (32'(frame_width_q) > mfb_pkg::COLUMNS) ?
		mfb_pkg::WU_W'(mfb_pkg::COLUMNS) : mfb_pkg::WU_W'(frame_width_q);
	assign hu = (32'(frame_height_q) > mfb_pkg::PAGES * 8) ?
		mfb_pkg::HU_W'(mfb_pkg::PAGES * 8) : mfb_pkg::HU_W'(frame_height_q);
	assign limit = mfb_pkg::LIM_W'(wu) * mfb_pkg::LIM_W'(mfb_pkg::PAGES);

	assign in_action = mfb_pkg::action_t'(s_tuser);
	assign in_x      = CW'($signed(s_tdata[15:0]));
	assign in_y      = CW'($signed(s_tdata[31:16]));
	assign in_ext    = s_tdata[47:32];
	assign in_color  = s_tdata[48];
	assign in_bidx   = s_tdata[58:49];
	assign in_bval   = s_tdata[66:59];
	assign bidx_ok   = (32'(in_bidx) < 32'(limit)) && (32'(in_bidx) < mfb_pkg::STORE_BYTES);

	assign s_tready = (state_q == mfb_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign hend_sum = in_x + $signed(CW'(in_ext));
	assign vend_sum = in_y + $signed(CW'(in_ext));

	// octant point of the current circle step
	assign oa = CW'(x_q);
	assign ob = CW'(y_q);
	always_comb begin
		case (oct_q)
			3'd0:    begin ox = cx_q + oa; oy = cy_q + ob; end
			3'd1:    begin ox = cx_q + ob; oy = cy_q + oa; end
			3'd2:    begin ox = cx_q - ob; oy = cy_q + oa; end
			3'd3:    begin ox = cx_q - oa; oy = cy_q + ob; end
			3'd4:    begin ox = cx_q - oa; oy = cy_q - ob; end
			3'd5:    begin ox = cx_q - ob; oy = cy_q - oa; end
			3'd6:    begin ox = cx_q + ob; oy = cy_q - oa; end
			default: begin ox = cx_q + oa; oy = cy_q - ob; end
		endcase
	end

	// pixel under consideration: the command's own anchor when idle
	always_comb begin
		if (state_q == mfb_pkg::ST_IDLE) begin
			px_c = in_x;
			py_c = in_y;
		end else begin
			case (cmd_q)
				mfb_pkg::ACT_HLINE:  begin px_c = cur_q; py_c = cy_q; end
				mfb_pkg::ACT_VLINE:  begin px_c = cx_q;  py_c = cur_q; end
				mfb_pkg::ACT_CIRCLE: begin px_c = ox;    py_c = oy; end
				default:             begin px_c = cx_q;  py_c = cy_q; end
			endcase
		end
	end

	assign inside_c = (px_c >= 0) && (py_c >= 0) &&
		(px_c < $signed(CW'(wu))) && (py_c < $signed(CW'(hu)));
	assign page_c   = py_c[mfb_pkg::PG_W+2:3];
	assign pix_addr = ADDR_W'(px_c[mfb_pkg::X_W-1:0]) + ADDR_W'(page_c) * ADDR_W'(wu);
	assign pix_bit  = 8'd1 << (py_c[2:0] & mfb_pkg::ROW_BIT_MASK);

	always_comb begin
		case (cmd_q)
			mfb_pkg::ACT_HLINE,
			mfb_pkg::ACT_VLINE:  done_c = (cur_q >= end_q);
			mfb_pkg::ACT_CIRCLE: done_c = (x_q < y_q);
			default:             done_c = 1'b1;
		endcase
	end

	// next state and store port control
	always_comb begin
		state_d   = state_q;
		ram_req   = '0;
		fin       = 1'b0;
		fin_rd    = mfb_pkg::BYTE_ZEROS;
		fin_ok    = 1'b0;
		latch_pix = 1'b0;
		adv       = 1'b0;
		cnt_inc   = 1'b0;
		case (state_q)
			mfb_pkg::ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = mfb_pkg::BYTE_ZEROS;
				cnt_inc       = 1'b1;
				if (cnt_q == ADDR_W'(mfb_pkg::STORE_BYTES - 1)) begin
					state_d = mfb_pkg::ST_IDLE;
				end
			end
			mfb_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_action)
						mfb_pkg::ACT_PIXEL: begin
							if (inside_c) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = pix_addr;
								latch_pix     = 1'b1;
								state_d       = mfb_pkg::ST_WRITE;
							end else begin
								fin = 1'b1;
							end
						end
						mfb_pkg::ACT_HLINE, mfb_pkg::ACT_VLINE: begin
							if (inside_c) begin
								state_d = mfb_pkg::ST_WALK;
							end else begin
								fin = 1'b1;
							end
						end
						mfb_pkg::ACT_CIRCLE: state_d = mfb_pkg::ST_WALK;
						mfb_pkg::ACT_FILL:   state_d = mfb_pkg::ST_FILL;
						mfb_pkg::ACT_WRITE: begin
							ram_req.we    = bidx_ok;
							ram_req.waddr = ADDR_W'(in_bidx);
							ram_req.wdata = in_bval;
							fin           = 1'b1;
							fin_ok        = bidx_ok;
						end
						mfb_pkg::ACT_READ: begin
							if (bidx_ok) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = ADDR_W'(in_bidx);
								state_d       = mfb_pkg::ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			mfb_pkg::ST_WALK: begin
				if (done_c) begin
					fin    = 1'b1;
					fin_ok = ok_q;
				end else if (inside_c) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = pix_addr;
					latch_pix     = 1'b1;
					state_d       = mfb_pkg::ST_WRITE;
				end else begin
					adv = 1'b1;
				end
			end
			mfb_pkg::ST_WRITE: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = addr_q;
				ram_req.wdata = color_q ? (ram_rdata | bit_q) : (ram_rdata & ~bit_q);
				if (cmd_q == mfb_pkg::ACT_PIXEL) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end else begin
					adv     = 1'b1;
					state_d = mfb_pkg::ST_WALK;
				end
			end
			mfb_pkg::ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = fill_q;
				cnt_inc       = 1'b1;
				if (cnt_q == ADDR_W'(mfb_pkg::STORE_BYTES - 1)) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end
			end
			mfb_pkg::ST_READ: begin
				fin    = 1'b1;
				fin_rd = ram_rdata;
				fin_ok = 1'b1;
			end
			mfb_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = mfb_pkg::ST_IDLE;
				end
			end
			default: state_d = mfb_pkg::ST_IDLE;
		endcase
		if (fin) begin
			state_d = out_free ? mfb_pkg::ST_IDLE : mfb_pkg::ST_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 8'd128;
			frame_height_q <= 7'd32;
		end else if (cfg_we) begin
			case (mfb_pkg::cfg_reg_t'(cfg_index))
				mfb_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mfb_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sweep address for the clearing pass and for fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (cnt_inc) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	// circle step: next y, and x stepping in when the error is non-negative
	assign y_n = y_q + RW'(1);
	assign x_n = x_q - RW'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_action;
			color_q <= in_color;
			cx_q    <= in_x;
			cy_q    <= in_y;
			ok_q    <= inside_c;
			fill_q  <= in_color ? mfb_pkg::BYTE_ONES : mfb_pkg::BYTE_ZEROS;
			oct_q   <= 3'd0;
			if (in_action == mfb_pkg::ACT_VLINE) begin
				cur_q <= in_y;
				end_q <= (vend_sum > $signed(CW'(hu))) ? CW'(hu) : vend_sum;
			end else begin
				cur_q <= in_x;
				end_q <= (hend_sum > $signed(CW'(wu))) ? CW'(wu) : hend_sum;
			end
			// a radius above the signed range starts with an empty loop
			if (in_ext[15]) begin
				x_q <= '0;
				y_q <= RW'(1);
			end else begin
				x_q <= RW'(in_ext);
				y_q <= '0;
			end
			err_q <= EW'(1) - EW'(in_ext);
		end else if (adv) begin
			if (cmd_q == mfb_pkg::ACT_CIRCLE) begin
				oct_q <= oct_q + 3'd1;
				if (oct_q == 3'd7) begin
					y_q <= y_n;
					if (err_q[EW-1]) begin
						err_q <= err_q + (EW'(y_n) <<< 1) + EW'(1);
					end else begin
						x_q   <= x_n;
						err_q <= err_q + ((EW'(y_n) - EW'(x_n) + EW'(1)) <<< 1);
					end
				end
			end else begin
				cur_q <= cur_q + CW'(1);
			end
		end
		if (latch_pix) begin
			addr_q <= pix_addr;
			bit_q  <= pix_bit;
		end
		if (fin && !out_free) begin
			res_rd_q <= fin_rd;
			res_ok_q <= fin_ok;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fin || state_q == mfb_pkg::ST_HOLD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			out_rd_q <= fin_rd;
			out_ok_q <= fin_ok;
		end else if (state_q == mfb_pkg::ST_HOLD && out_free) begin
			out_rd_q <= res_rd_q;
			out_ok_q <= res_ok_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rd_q;
	assign m_tuser  = out_ok_q;

endmodule

FILE: hw/rtl/mfb_checker.sv
// port-level checker of the draw engine and its bind to the top level
`include "mono_framebuffer_draw_engine_macros.svh"

module mfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	// items accepted and not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
		end
	end

	`ASSERT_AT_CLK(a_result_held, m_tvalid && !m_tready |=> m_tvalid, "stalled result item dropped")
	`ASSERT_AT_CLK(a_zero_outside, m_tvalid && !m_tuser |-> m_tdata == 8'h00, "read byte not zero")
	`ASSERT_NEVER(a_no_orphan, m_tvalid && m_tready && pend_q == 2'd0, "result without an item")
	`ASSERT_NEVER(a_one_ahead, s_tvalid && s_tready && pend_q > 2'd1, "item taken while two pending")

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (.*);
